// ===== sv/phb_pkg.sv =====
// ----------------------------------------------------------------------------
// Peak-hold bar meter package
// Shared sizes, register indexes, reset values and the per-column record type.
// ----------------------------------------------------------------------------
package phb_pkg;

  // Display geometry.
  localparam int COLUMNS = 64;
  localparam int ROWS    = 32;

  // Field widths.
  localparam int COL_W  = 6;
  localparam int LVL_W  = 6;
  localparam int TICK_W = 32;
  localparam int INTV_W = 16;

  // Column store address width.
  localparam int COL_AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_BAR_FALL     = 2'd0;
  localparam reg_idx_t REG_MARKER_HOVER = 2'd1;
  localparam reg_idx_t REG_MARKER_FALL  = 2'd2;

  localparam logic [INTV_W-1:0] BAR_FALL_RST     = INTV_W'(20);
  localparam logic [INTV_W-1:0] MARKER_HOVER_RST = INTV_W'(120);
  localparam logic [INTV_W-1:0] MARKER_FALL_RST  = INTV_W'(30);

  // State kept for one column.
  typedef struct packed {
    logic [LVL_W-1:0]  bar;
    logic [TICK_W-1:0] bar_fall_start;
    logic [LVL_W-1:0]  marker;
    logic [TICK_W-1:0] marker_hover_start;
    logic [TICK_W-1:0] marker_fall_start;
  } col_rec_t;

endpackage

// ===== sv/phb_in_if.sv =====
// ----------------------------------------------------------------------------
// Peak-hold bar meter input channel
// Valid/ready channel carrying one column level sample.
// ----------------------------------------------------------------------------
interface phb_in_if;
  logic                      valid;
  logic                      ready;
  logic [phb_pkg::COL_W-1:0]  column;
  logic [phb_pkg::LVL_W-1:0]  level;
  logic [phb_pkg::TICK_W-1:0] now;

  modport source (output valid, column, level, now, input ready);
  modport sink   (input valid, column, level, now, output ready);
endinterface

// ===== sv/phb_out_if.sv =====
// ----------------------------------------------------------------------------
// Peak-hold bar meter result channel
// Valid/ready channel carrying the updated bar and marker of one column.
// ----------------------------------------------------------------------------
interface phb_out_if;
  logic                     valid;
  logic                     ready;
  logic [phb_pkg::COL_W-1:0] column_out;
  logic [phb_pkg::LVL_W-1:0] bar_height;
  logic [phb_pkg::LVL_W-1:0] marker_height;

  modport source (output valid, column_out, bar_height, marker_height, input ready);
  modport sink   (input valid, column_out, bar_height, marker_height, output ready);
endinterface

// ===== sv/peak_hold_bar_meter.sv =====
// Items pass through stage 1 and the output register. Throughput: one item per
// cycle while the output is not stalled; the column record memory is read at
// the input transfer and written back when the item moves into the output
// register. A write to the column being read in the same cycle is forwarded.
// Reset (rst_n low, synchronous) clears the per-column valid bits, so every
// column reads as zero, and loads the interval registers with their defaults.
// ----------------------------------------------------------------------------
// Peak-hold bar meter
// Per-column bar with a falling peak marker, one column record per item.
// ----------------------------------------------------------------------------
module peak_hold_bar_meter (
  input  logic                        clk,
  input  logic                        rst_n,
  phb_in_if.sink                      in_ch,
  phb_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [phb_pkg::ADDR_W-1:0]  paddr,
  input  logic [phb_pkg::DATA_W-1:0]  pwdata,
  output logic [phb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // Configuration registers.
  logic [phb_pkg::INTV_W-1:0] bar_fall_int_r;
  logic [phb_pkg::INTV_W-1:0] marker_hover_int_r;
  logic [phb_pkg::INTV_W-1:0] marker_fall_int_r;
  phb_pkg::reg_idx_t          reg_idx;
  logic                       cfg_wr;

  // Column record memory and its valid bits.
  phb_pkg::col_rec_t          mem_r [phb_pkg::COLUMNS];
  logic [phb_pkg::COLUMNS-1:0] col_vld_r;

  // Stage 1: item whose record is being read.
  logic                       s1_valid_r;
  logic [phb_pkg::COL_W-1:0]  s1_col_r;
  logic [phb_pkg::LVL_W-1:0]  s1_lvl_r;
  logic [phb_pkg::TICK_W-1:0] s1_now_r;
  phb_pkg::col_rec_t          mem_q_r;
  phb_pkg::col_rec_t          byp_r;
  logic                       byp_sel_r;
  logic                       rec_vld_r;

  // Output register.
  logic                       out_valid_r;
  logic [phb_pkg::COL_W-1:0]  out_col_r;
  logic [phb_pkg::LVL_W-1:0]  out_bar_r;
  logic [phb_pkg::LVL_W-1:0]  out_mark_r;

  // Handshake and write-back control.
  logic                       out_free;
  logic                       s1_fire;
  logic                       in_fire;
  logic                       in_range;
  logic                       wr_en;
  logic [phb_pkg::COL_AW-1:0] wr_addr;
  logic [phb_pkg::COL_AW-1:0] rd_addr;
  logic                       fwd_hit;

  // Update datapath.
  phb_pkg::col_rec_t          cur;
  phb_pkg::col_rec_t          upd;
  logic [phb_pkg::LVL_W-1:0]  lvl_sat;
  logic                       bar_to;
  logic                       hover_to;
  logic                       fall_to;
  logic                       hover_ok;
  logic                       mark_jump;
  logic [phb_pkg::LVL_W-1:0]  res_bar;
  logic [phb_pkg::LVL_W-1:0]  res_mark;

  // APB access: always ready, written during the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[phb_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_fall_int_r     <= phb_pkg::BAR_FALL_RST;
      marker_hover_int_r <= phb_pkg::MARKER_HOVER_RST;
      marker_fall_int_r  <= phb_pkg::MARKER_FALL_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        phb_pkg::REG_BAR_FALL:     bar_fall_int_r     <= pwdata[phb_pkg::INTV_W-1:0];
        phb_pkg::REG_MARKER_HOVER: marker_hover_int_r <= pwdata[phb_pkg::INTV_W-1:0];
        phb_pkg::REG_MARKER_FALL:  marker_fall_int_r  <= pwdata[phb_pkg::INTV_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      phb_pkg::REG_BAR_FALL:     prdata = phb_pkg::DATA_W'(bar_fall_int_r);
      phb_pkg::REG_MARKER_HOVER: prdata = phb_pkg::DATA_W'(marker_hover_int_r);
      phb_pkg::REG_MARKER_FALL:  prdata = phb_pkg::DATA_W'(marker_fall_int_r);
      default:                   prdata = '0;
    endcase
  end

  // Pipeline flow: stage 1 moves on when the output register is free.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Write-back of the stage 1 record; a read of the same column is forwarded.
  assign in_range = {1'b0, s1_col_r} < (phb_pkg::COL_W + 1)'(phb_pkg::COLUMNS);
  assign wr_en    = s1_fire && in_range;
  assign wr_addr  = s1_col_r[phb_pkg::COL_AW-1:0];
  assign rd_addr  = in_ch.column[phb_pkg::COL_AW-1:0];
  assign fwd_hit  = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= upd;
    end
    if (in_fire) begin
      mem_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_vld_r <= '0;
    end else if (wr_en) begin
      col_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r  <= in_ch.column;
      s1_lvl_r  <= in_ch.level;
      s1_now_r  <= in_ch.now;
      byp_r     <= upd;
      byp_sel_r <= fwd_hit;
      rec_vld_r <= col_vld_r[rd_addr];
    end
  end

  // Current record: forwarded, stored, or the cleared value.
  always_comb begin
    if (byp_sel_r) begin
      cur = byp_r;
    end else if (rec_vld_r) begin
      cur = mem_q_r;
    end else begin
      cur = '0;
    end
  end

  // Timeouts on wrapping elapsed time.
  assign bar_to   = (s1_now_r - cur.bar_fall_start) >= phb_pkg::TICK_W'(bar_fall_int_r);
  assign hover_to = (s1_now_r - cur.marker_hover_start) >=
                    phb_pkg::TICK_W'(marker_hover_int_r);
  assign fall_to  = (s1_now_r - cur.marker_fall_start) >=
                    phb_pkg::TICK_W'(marker_fall_int_r);
  assign lvl_sat  = (s1_lvl_r > phb_pkg::LVL_W'(phb_pkg::ROWS)) ?
                    phb_pkg::LVL_W'(phb_pkg::ROWS) : s1_lvl_r;

  // Bar and marker update.
  always_comb begin
    upd = cur;
    if (lvl_sat < cur.bar) begin
      if (bar_to) begin
        upd.bar            = cur.bar - 1'b1;
        upd.bar_fall_start = s1_now_r;
      end
    end else if (lvl_sat > cur.bar) begin
      upd.bar = lvl_sat;
    end

    // A marker lifted by the bar restarts its hover time at this tick.
    mark_jump = upd.bar > cur.marker;
    hover_ok  = mark_jump ? (marker_hover_int_r == '0) : hover_to;
    if (upd.bar != cur.marker) begin
      if (mark_jump) begin
        upd.marker             = upd.bar;
        upd.marker_hover_start = s1_now_r;
      end
      if (hover_ok && fall_to) begin
        upd.marker_fall_start = s1_now_r;
        if (upd.marker != '0) begin
          upd.marker = upd.marker - 1'b1;
        end
      end
    end
    if (upd.marker == '0) begin
      upd.marker = phb_pkg::LVL_W'(1);
    end
  end

  // A column outside the display reports an empty bar and the lowest marker.
  assign res_bar  = in_range ? upd.bar : '0;
  assign res_mark = in_range ? upd.marker : phb_pkg::LVL_W'(1);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_col_r  <= s1_col_r;
      out_bar_r  <= res_bar;
      out_mark_r <= res_mark;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.column_out    = out_col_r;
  assign out_ch.bar_height    = out_bar_r;
  assign out_ch.marker_height = out_mark_r;

endmodule
